>>> design/tsq_pkg.sv
// Shared types and constants for the touch sample qualifier with box filter.
`default_nettype none

package tsq_pkg;

    // Field widths.
    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int SUM_W   = 23;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_MIN_VALID_TOUCH   = 2'd0;
    localparam logic [1:0] REG_MAX_VALID_TOUCH   = 2'd1;
    localparam logic [1:0] REG_VALIDITY_DELAY_MS = 2'd2;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] MIN_VALID_RESET = 16'd0;
    localparam logic [LEVEL_W-1:0] MAX_VALID_RESET = 16'hFFFF;
    localparam logic [DELAY_W-1:0] DELAY_RESET     = 16'd250;

    // Gate level that marks a frame to be ignored.
    localparam logic [LEVEL_W-1:0] GATE_IGNORE = 16'hFFFF;

    // Configuration handed to the qualifier.
    typedef struct packed {
        logic [LEVEL_W-1:0] min_valid_touch;
        logic [LEVEL_W-1:0] max_valid_touch;
        logic [DELAY_W-1:0] validity_delay_ms;
    } cfg_t;

    // Qualifier status after the current update.
    typedef struct packed {
        logic [LEVEL_W-1:0] touch_level;
        logic               sensor_valid;
        logic               deadline_pending;
    } qual_status_t;

    // One result as it waits in the output buffer.
    typedef struct packed {
        logic [LEVEL_W-1:0] touch_level;
        logic [SUM_W-1:0]   window_sum;
        logic               sensor_valid;
        logic               deadline_pending;
    } result_t;

endpackage

`default_nettype wire

>>> design/tsq_if.sv
// Valid/ready channel interfaces for sensor frames and results.
`default_nettype none

interface tsq_frame_if;
    logic                         valid;
    logic                         ready;
    logic [tsq_pkg::LEVEL_W-1:0]  gate_level;
    logic [tsq_pkg::LEVEL_W-1:0]  touch_raw;
    logic                         on_charger;
    logic [tsq_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, gate_level, touch_raw, on_charger, now_ms, input ready);
    modport sink   (input valid, gate_level, touch_raw, on_charger, now_ms, output ready);
endinterface

interface tsq_result_if;
    logic                         valid;
    logic                         ready;
    logic [tsq_pkg::LEVEL_W-1:0]  touch_level;
    logic [tsq_pkg::SUM_W-1:0]    window_sum;
    logic                         sensor_valid;
    logic                         deadline_pending;

    modport source (output valid, touch_level, window_sum, sensor_valid, deadline_pending,
                    input ready);
    modport sink   (input valid, touch_level, window_sum, sensor_valid, deadline_pending,
                    output ready);
endinterface

`default_nettype wire

>>> design/tsq_cell.sv
// One window cell: holds a sample and passes it to its neighbor on each shift.
`default_nettype none

module tsq_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        shift,
    input  wire logic [tsq_pkg::LEVEL_W-1:0] d,
    output logic      [tsq_pkg::LEVEL_W-1:0] q
);

    logic [tsq_pkg::LEVEL_W-1:0] sample_reg;
    logic [tsq_pkg::LEVEL_W-1:0] sample_next;

    // Take the neighbor's sample on a shift, otherwise hold.
    always_comb
    begin
        sample_next = shift ? d : sample_reg;
    end

    // The window starts cleared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    assign q = sample_reg;

endmodule

`default_nettype wire

>>> design/tsq_window.sv
// Box filter window: a chain of cells with a running sum over its contents.
`default_nettype none

module tsq_window #(
    parameter int WINDOW_LEN = 80
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        shift,
    input  wire logic [tsq_pkg::LEVEL_W-1:0] sample,
    output logic      [tsq_pkg::SUM_W-1:0]   sum_next
);

    logic [tsq_pkg::LEVEL_W-1:0] tap [WINDOW_LEN];
    logic [tsq_pkg::SUM_W-1:0]   sum_reg;

    // The chain: the first cell takes the new sample, each later cell its neighbor's.
    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            tsq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (sample),
                .q     (tap[i])
            );
        end
        else
        begin : g_body
            tsq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (tap[i-1]),
                .q     (tap[i])
            );
        end
    end

    // The last cell holds the oldest sample, which leaves the window on a shift.
    always_comb
    begin
        if (shift)
        begin
            sum_next = sum_reg - tsq_pkg::SUM_W'(tap[WINDOW_LEN-1])
                               + tsq_pkg::SUM_W'(sample);
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    // Running sum, kept modulo two to the sum width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

>>> design/tsq_qualifier.sv
// Range check, invalidation deadline and sticky invalid flag.
`default_nettype none

module tsq_qualifier (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [tsq_pkg::LEVEL_W-1:0] touch_raw,
    input  wire logic                        on_charger,
    input  wire logic [tsq_pkg::TIME_W-1:0]  now_ms,
    input  wire tsq_pkg::cfg_t               cfg,
    output tsq_pkg::qual_status_t            status_next
);

    logic [tsq_pkg::LEVEL_W-1:0] level_reg;
    logic [tsq_pkg::LEVEL_W-1:0] level_next;
    logic [tsq_pkg::TIME_W-1:0]  deadline_reg;
    logic [tsq_pkg::TIME_W-1:0]  deadline_next;
    logic                        invalid_reg;
    logic                        invalid_next;

    logic                        out_of_range;
    logic [tsq_pkg::TIME_W-1:0]  armed_time;
    logic [tsq_pkg::TIME_W-1:0]  deadline_mid;

    // Arm on an out-of-range level off the charger, cancel on the charger,
    // and fire once the time is strictly past the deadline.
    always_comb
    begin
        out_of_range = (touch_raw < cfg.min_valid_touch) || (touch_raw > cfg.max_valid_touch);
        armed_time   = now_ms + tsq_pkg::TIME_W'(cfg.validity_delay_ms);

        if (on_charger)
        begin
            deadline_mid = '0;
        end
        else if (out_of_range && (deadline_reg == '0))
        begin
            deadline_mid = armed_time;
        end
        else
        begin
            deadline_mid = deadline_reg;
        end

        level_next    = level_reg;
        deadline_next = deadline_reg;
        invalid_next  = invalid_reg;
        if (step)
        begin
            level_next = touch_raw;
            if ((deadline_mid != '0) && (now_ms > deadline_mid))
            begin
                deadline_next = '0;
                invalid_next  = 1'b1;
            end
            else
            begin
                deadline_next = deadline_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            deadline_reg <= '0;
            invalid_reg  <= 1'b0;
        end
        else
        begin
            level_reg    <= level_next;
            deadline_reg <= deadline_next;
            invalid_reg  <= invalid_next;
        end
    end

    // Status after this update, for the result of the current request.
    always_comb
    begin
        status_next.touch_level      = level_next;
        status_next.sensor_valid     = !invalid_next;
        status_next.deadline_pending = (deadline_next != '0);
    end

endmodule

`default_nettype wire

>>> design/touch_sample_qualifier_box_filter.sv
// Top level: configuration registers, qualifier, box filter window and output buffer.
//
// Usage:
//   frames  - sensor frame requests (gate_level, touch_raw, on_charger, now_ms) on a
//             valid/ready sink; a request is taken when valid and ready are both high.
//   results - one result request per frame (touch_level, window_sum, sensor_valid,
//             deadline_pending) on a valid/ready source.
//   APB     - three 16-bit registers at byte addresses 0, 4 and 8: min_valid_touch,
//             max_valid_touch, validity_delay_ms. pready is always high; write only
//             while no frame is in flight.
// A frame's result is valid in the cycle after it is taken unless earlier results wait.
// One frame per cycle is taken while ready is high; the window is a chain of WINDOW_LEN
// cells that all shift together on every frame that is not ignored, so the oldest sample
// is always at the end of the chain and the running sum needs one add and one subtract.
// Results go to a two-entry output buffer; ready stays high while one result waits,
// and drops only when both entries are full because the receiver stalls.
// Reset clears the window cells, the running sum, the deadline and the invalid flag
// and loads the register reset values; no clearing pass is needed.
`default_nettype none

module touch_sample_qualifier_box_filter #(
    parameter int WINDOW_LEN = 80
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tsq_frame_if.sink                         frames,
    tsq_result_if.source                      results,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tsq_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tsq_pkg::DATA_W-1:0]   pwdata,
    output logic      [tsq_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    tsq_pkg::cfg_t           cfg_reg;
    tsq_pkg::cfg_t           cfg_next;
    logic [1:0]              reg_index;
    logic                    cfg_write;

    logic                    accept;
    logic                    shift;
    tsq_pkg::qual_status_t   status_next;
    logic [tsq_pkg::SUM_W-1:0] sum_next;
    tsq_pkg::result_t        result_new;

    tsq_pkg::result_t        buf0_reg;
    tsq_pkg::result_t        buf0_next;
    tsq_pkg::result_t        buf1_reg;
    tsq_pkg::result_t        buf1_next;
    logic [1:0]              count_reg;
    logic [1:0]              count_next;
    logic                    pop;

    // Configuration write decode.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                tsq_pkg::REG_MIN_VALID_TOUCH:
                    cfg_next.min_valid_touch = pwdata[tsq_pkg::LEVEL_W-1:0];
                tsq_pkg::REG_MAX_VALID_TOUCH:
                    cfg_next.max_valid_touch = pwdata[tsq_pkg::LEVEL_W-1:0];
                tsq_pkg::REG_VALIDITY_DELAY_MS:
                    cfg_next.validity_delay_ms = pwdata[tsq_pkg::DELAY_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_valid_touch   <= tsq_pkg::MIN_VALID_RESET;
            cfg_reg.max_valid_touch   <= tsq_pkg::MAX_VALID_RESET;
            cfg_reg.validity_delay_ms <= tsq_pkg::DELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read back.
    always_comb
    begin
        case (reg_index)
            tsq_pkg::REG_MIN_VALID_TOUCH:
                prdata = tsq_pkg::DATA_W'(cfg_reg.min_valid_touch);
            tsq_pkg::REG_MAX_VALID_TOUCH:
                prdata = tsq_pkg::DATA_W'(cfg_reg.max_valid_touch);
            tsq_pkg::REG_VALIDITY_DELAY_MS:
                prdata = tsq_pkg::DATA_W'(cfg_reg.validity_delay_ms);
            default:
                prdata = '0;
        endcase
    end

    // Frame acceptance; ignored frames still produce a result but change nothing.
    assign frames.ready = (count_reg != 2'd2);
    assign accept       = frames.valid && frames.ready;
    assign shift        = accept && (frames.gate_level != tsq_pkg::GATE_IGNORE);

    tsq_qualifier u_qualifier (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (shift),
        .touch_raw   (frames.touch_raw),
        .on_charger  (frames.on_charger),
        .now_ms      (frames.now_ms),
        .cfg         (cfg_reg),
        .status_next (status_next)
    );

    tsq_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .sample   (frames.touch_raw),
        .sum_next (sum_next)
    );

    always_comb
    begin
        result_new.touch_level      = status_next.touch_level;
        result_new.window_sum       = sum_next;
        result_new.sensor_valid     = status_next.sensor_valid;
        result_new.deadline_pending = status_next.deadline_pending;
    end

    // Two-entry output buffer; entry zero is the head.
    assign pop = results.valid && results.ready;

    always_comb
    begin
        buf0_next  = buf0_reg;
        buf1_next  = buf1_reg;
        count_next = count_reg;
        if (pop)
        begin
            buf0_next = buf1_reg;
        end
        if (accept)
        begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop))
            begin
                buf0_next = result_new;
            end
            else
            begin
                buf1_next = result_new;
            end
        end
        if (accept && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !accept)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    assign results.valid            = (count_reg != 2'd0);
    assign results.touch_level      = buf0_reg.touch_level;
    assign results.window_sum       = buf0_reg.window_sum;
    assign results.sensor_valid     = buf0_reg.sensor_valid;
    assign results.deadline_pending = buf0_reg.deadline_pending;

endmodule

`default_nettype wire

>>> tb/sv/touch_sample_qualifier_box_filter_test.sv
// Testbench for the touch sample qualifier with box filter: directed and random frames.
module touch_sample_qualifier_box_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tsq_pkg::*;

    localparam int WINDOW_LEN = 80;
    // Generous bound: every frame waiting out a long sender gap and a long receiver stall.
    localparam int CYCLE_LIMIT = 600000;
    // Settle after the last due result, to cover any straggler from the block.
    localparam int SETTLE_CYCLES = 4;
    localparam int MISMATCH_REPORTS = 10;
    // Register index past the last mapped register; writes to it must have no effect.
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    tsq_frame_if  frames_if();
    tsq_result_if results_if();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Register copies used by the qualifier prediction.
    logic [LEVEL_W-1:0] range_lo;
    logic [LEVEL_W-1:0] range_hi;
    logic [DELAY_W-1:0] settle_ms;

    // Predicted qualifier and window state.
    logic [LEVEL_W-1:0] level_hold;
    logic [LEVEL_W-1:0] window_cells [WINDOW_LEN];
    int                 next_cell;
    logic [31:0]        sum_acc;
    logic [TIME_W-1:0]  invalidate_at;
    logic               sensor_dead;

    // Results due from the block, oldest first.
    result_t qualified_results [$];

    int          mismatch_count = 0;
    int          frames_filtered = 0;
    int          cycle_count = 0;
    int          hold_off_request = 0;
    logic        steady_flow = 1'b0;
    logic [31:0] clock_ms = 32'd0;

    touch_sample_qualifier_box_filter #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frames (frames_if),
        .results(results_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Prediction: apply one frame to the state copy and return the result it causes.
    function automatic result_t qualify_and_filter(input logic [LEVEL_W-1:0] gate,
                                                   input logic [LEVEL_W-1:0] raw,
                                                   input logic chg,
                                                   input logic [TIME_W-1:0] now);
        result_t r;
        if (gate != GATE_IGNORE)
        begin
            level_hold = raw;
            // Off the charger an out-of-range level arms a deadline; the charger cancels it.
            if (!chg)
            begin
                if ((raw < range_lo || raw > range_hi) && invalidate_at == '0)
                    invalidate_at = now + TIME_W'(settle_ms);
            end
            else
            begin
                invalidate_at = '0;
            end
            // A deadline strictly in the past invalidates the sensor for good.
            if (invalidate_at != '0 && now > invalidate_at)
            begin
                invalidate_at = '0;
                sensor_dead = 1'b1;
            end
            // Circular window with a running sum.
            sum_acc = sum_acc - 32'(window_cells[next_cell]) + 32'(level_hold);
            window_cells[next_cell] = level_hold;
            next_cell = (next_cell == WINDOW_LEN - 1) ? 0 : next_cell + 1;
        end
        r.touch_level      = level_hold;
        r.window_sum       = sum_acc[SUM_W-1:0];
        r.sensor_valid     = ~sensor_dead;
        r.deadline_pending = (invalidate_at != '0);
        return r;
    endfunction

    function automatic void clear_prediction();
        range_lo      = MIN_VALID_RESET;
        range_hi      = MAX_VALID_RESET;
        settle_ms     = DELAY_RESET;
        level_hold    = '0;
        next_cell     = 0;
        sum_acc       = '0;
        invalidate_at = '0;
        sensor_dead   = 1'b0;
        for (int i = 0; i < WINDOW_LEN; i++)
            window_cells[i] = '0;
    endfunction

    // Sender gap: mostly none, often short, now and then long.
    function automatic int idle_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Millisecond stamp: mostly a slowly advancing clock, sometimes a big step or a jump.
    function automatic logic [TIME_W-1:0] next_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            clock_ms = clock_ms + $urandom_range(0, 40);
        else if (r < 95)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 70000);
        return clock_ms;
    endfunction

    // Touch level: in range, outside it, or anything at all.
    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        int lo_v;
        int hi_v;
        r = $urandom_range(0, 99);
        lo_v = range_lo;
        hi_v = range_hi;
        if (r < 45 && lo_v <= hi_v)
            return LEVEL_W'($urandom_range(hi_v, lo_v));
        if (r < 80)
        begin
            if (lo_v > 0 && (hi_v == 65535 || $urandom_range(0, 1) == 0))
                return LEVEL_W'($urandom_range(lo_v - 1, 0));
            if (hi_v < 65535)
                return LEVEL_W'($urandom_range(65535, hi_v + 1));
        end
        return LEVEL_W'($urandom());
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_gate();
        if ($urandom_range(0, 99) < 8)
            return GATE_IGNORE;
        return LEVEL_W'($urandom());
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_REPORTS)
            $display("mismatch on %0s at %0t: expected 0x%0h, got 0x%0h",
                     field, $realtime, want_v, got_v);
    endtask

    // Offer one frame request and hold it until the block takes it.
    task automatic send_frame(input logic [LEVEL_W-1:0] gate, input logic [LEVEL_W-1:0] raw,
                              input logic chg, input logic [TIME_W-1:0] now);
        int   gap;
        logic taken;
        gap = idle_gap();
        if (gap > 0)
        begin
            frames_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frames_if.valid      <= 1'b1;
        frames_if.gate_level <= gate;
        frames_if.touch_raw  <= raw;
        frames_if.on_charger <= chg;
        frames_if.now_ms     <= now;
        taken = 1'b0;
        while (!taken)
        begin
            // Ready is settled mid-cycle; it decides the request at the next rising edge.
            @(negedge clk);
            taken = frames_if.ready;
            if (taken)
                qualified_results.push_back(qualify_and_filter(gate, raw, chg, now));
            @(posedge clk);
        end
        if (gate != GATE_IGNORE)
            frames_filtered++;
    endtask

    task automatic send_random_frame();
        send_frame(pick_gate(), pick_level(), $urandom_range(0, 3) == 0, next_now());
    endtask

    // Stop offering and wait until every result has come back.
    task automatic wait_idle();
        frames_if.valid <= 1'b0;
        while (qualified_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready, then one idle cycle.
    task automatic apb_write(input logic [1:0] index, input logic [DATA_W-1:0] value);
        logic done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (index)
            REG_MIN_VALID_TOUCH:   range_lo = value[LEVEL_W-1:0];
            REG_MAX_VALID_TOUCH:   range_hi = value[LEVEL_W-1:0];
            REG_VALIDITY_DELAY_MS: settle_ms = value[DELAY_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits are random; only the low 16 bits of each register count.
    task automatic configure(input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi,
                             input logic [DELAY_W-1:0] delay);
        wait_idle();
        apb_write(REG_MIN_VALID_TOUCH, {16'($urandom()), lo});
        apb_write(REG_MAX_VALID_TOUCH, {16'($urandom()), hi});
        apb_write(REG_VALIDITY_DELAY_MS, {16'($urandom()), delay});
    endtask

    // Reset registers: ignored frame first, then field extremes.
    task automatic test_reset_values();
        send_frame(GATE_IGNORE, 16'h1234, 1'b0, 32'd100);
        send_frame(16'h0000, 16'h0000, 1'b0, 32'h0000_0000);
        send_frame(16'hFFFE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_frame(16'h5A5A, 16'hA5A5, 1'b0, 32'd5);
    endtask

    // Range edges, arming, charger cancel, and a deadline that is reached but not passed.
    task automatic test_range_boundaries();
        configure(16'd100, 16'd200, 16'd10);
        send_frame(16'h0001, 16'd50, 1'b0, 32'd1000);
        send_frame(16'h0002, 16'd300, 1'b0, 32'd1005);
        send_frame(16'h0004, 16'd150, 1'b1, 32'd1006);
        send_frame(16'h0008, 16'd250, 1'b0, 32'd2000);
        send_frame(16'h0010, 16'd150, 1'b0, 32'd2010);
        send_frame(GATE_IGNORE, 16'd7, 1'b1, 32'd5000);
        send_frame(16'h0020, 16'd100, 1'b1, 32'd2011);
        send_frame(16'h0040, 16'd200, 1'b0, 32'd2012);
    endtask

    // A deadline that wraps to zero is not armed; a late deadline versus an early stamp.
    task automatic test_deadline_wrap();
        send_frame(16'h0080, 16'd99, 1'b0, 32'hFFFF_FFF6);
        send_frame(16'h0100, 16'd201, 1'b0, 32'hFFFF_FFF0);
        send_frame(16'h0200, 16'd201, 1'b0, 32'd3);
        send_frame(16'h0400, 16'd0, 1'b1, 32'd4);
    endtask

    // Inverted range: every level is out of range, so the deadline runs out.
    task automatic test_inverted_range_expiry();
        configure(16'd200, 16'd100, 16'd10);
        send_frame(16'h0800, 16'd150, 1'b1, 32'd10);
        send_frame(16'h1000, 16'd150, 1'b0, 32'd20);
        send_frame(16'h2000, 16'd150, 1'b0, 32'd31);
        send_frame(16'h4000, 16'd150, 1'b0, 32'd32);
    endtask

    // A write past the last register must leave the configuration alone.
    task automatic test_unmapped_register();
        wait_idle();
        apb_write(REG_UNMAPPED, 32'hFFFF_0001);
        send_frame(16'h8000, 16'd150, 1'b0, 32'd50);
    endtask

    task automatic test_random_traffic(input logic [LEVEL_W-1:0] lo,
                                       input logic [LEVEL_W-1:0] hi,
                                       input logic [DELAY_W-1:0] delay,
                                       input int count, input logic smooth);
        int target;
        configure(lo, hi, delay);
        steady_flow = smooth;
        target = frames_filtered + count;
        while (frames_filtered < target)
            send_random_frame();
        steady_flow = 1'b0;
    endtask

    // Receiver holds off long while frames keep coming; then the sender drains and resumes.
    task automatic test_output_stall();
        wait_idle();
        hold_off_request = 120;
        steady_flow = 1'b1;
        repeat (40) send_random_frame();
        steady_flow = 1'b0;
        wait_idle();
        repeat (20) send_random_frame();
    endtask

    // Fill the window with the largest level, then flush it back to zero.
    task automatic test_full_window();
        configure(MIN_VALID_RESET, MAX_VALID_RESET, DELAY_RESET);
        repeat (WINDOW_LEN + 10) send_frame(16'h0100, 16'hFFFF, 1'b1, next_now());
        repeat (WINDOW_LEN + 5) send_frame(16'h0100, 16'h0000, 1'b1, next_now());
    endtask

    // Receiver: random ready with short and long stalls, or a requested hold-off.
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                results_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                results_if.ready <= 1'b0;
                stall_left--;
            end
            else if (hold_off_request > 0)
            begin
                results_if.ready <= 1'b0;
                stall_left = hold_off_request - 1;
                hold_off_request = 0;
            end
            else if (steady_flow)
            begin
                results_if.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    results_if.ready <= 1'b1;
                end
                else
                begin
                    results_if.ready <= 1'b0;
                    stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    // Result check: each taken result against the oldest one due.
    initial
    begin
        result_t seen;
        result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1)
            begin
                seen.touch_level      = results_if.touch_level;
                seen.window_sum       = results_if.window_sum;
                seen.sensor_valid     = results_if.sensor_valid;
                seen.deadline_pending = results_if.deadline_pending;
                if (qualified_results.size() == 0)
                begin
                    report_mismatch("result with none due, touch_level", 32'd0,
                                    32'(seen.touch_level));
                end
                else
                begin
                    want = qualified_results.pop_front();
                    if (seen.touch_level !== want.touch_level)
                        report_mismatch("touch_level", 32'(want.touch_level),
                                        32'(seen.touch_level));
                    if (seen.window_sum !== want.window_sum)
                        report_mismatch("window_sum", 32'(want.window_sum),
                                        32'(seen.window_sum));
                    if (seen.sensor_valid !== want.sensor_valid)
                        report_mismatch("sensor_valid", 32'(want.sensor_valid),
                                        32'(seen.sensor_valid));
                    if (seen.deadline_pending !== want.deadline_pending)
                        report_mismatch("deadline_pending", 32'(want.deadline_pending),
                                        32'(seen.deadline_pending));
                end
            end
        end
    end

    // Watchdog on the cycle count.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Test sequence.
    initial
    begin
        clear_prediction();
        rst_n                <= 1'b0;
        frames_if.valid      <= 1'b0;
        frames_if.gate_level <= '0;
        frames_if.touch_raw  <= '0;
        frames_if.on_charger <= 1'b0;
        frames_if.now_ms     <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_range_boundaries();
        test_deadline_wrap();
        test_inverted_range_expiry();
        test_unmapped_register();

        test_random_traffic(16'd1000, 16'd60000, 16'hFFFF, 200, 1'b0);
        test_random_traffic(MIN_VALID_RESET, MAX_VALID_RESET, DELAY_RESET, 150, 1'b1);
        test_random_traffic(16'd30000, 16'd30000, 16'd0, 200, 1'b0);
        test_output_stall();
        test_random_traffic(16'hFFFF, 16'd0, 16'd40, 200, 1'b0);
        test_random_traffic(16'd0, 16'd0, 16'd5, 150, 1'b0);
        test_full_window();
        test_random_traffic(16'hFFFF, 16'hFFFF, 16'hFFFF, 150, 1'b0);
        test_random_traffic(16'd500, 16'd20000, 16'd100, 200, 1'b0);
        test_random_traffic(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 300)),
                            200, 1'b0);

        wait_idle();
        if (mismatch_count == 0 && qualified_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
